@@ rtl/ihtd_pkg.sv @@
// ----------------------------------------------------------------------------
// ihtd_pkg
// Shared types and constants for the interrupt handler table and dispatcher.
// ----------------------------------------------------------------------------
package ihtd_pkg;

   localparam int SLOT_COUNT  = 16;
   localparam int VECTOR_BITS = 8;
   localparam int SLOT_BITS   = $clog2(SLOT_COUNT);

   localparam int MASK_BITS   = 32;
   localparam int ID_BITS     = 8;
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;
   localparam int DSLOT_BITS  = 4;

   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 24;

   localparam logic [MASK_BITS-1:0] FIFO_MASK_RESET = 32'h0004_0000;

   localparam logic [CMD_BITS-1:0] CMD_REGISTER = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_QUERY    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_DISPATCH = 2'd2;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_MASK = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NO_MATCH  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                   en;
      logic [SLOT_BITS-1:0]   idx;
      logic [MASK_BITS-1:0]   mask;
      logic [VECTOR_BITS-1:0] handler;
   } table_write_type;

   typedef struct packed {
      logic done;
      logic found;
   } match_result_type;

endpackage

@@ rtl/ihtd_table.sv @@
// ----------------------------------------------------------------------------
// ihtd_table
// Slot storage: interrupt mask and handler vector per slot, with valid bits.
// ----------------------------------------------------------------------------
module ihtd_table (
   input  logic                            clock,
   input  logic                            reset,
   input  ihtd_pkg::table_write_type       wr,
   input  logic [ihtd_pkg::SLOT_BITS-1:0]  rd_idx,
   output logic [ihtd_pkg::MASK_BITS-1:0]  rd_mask,
   output logic [ihtd_pkg::VECTOR_BITS-1:0] rd_handler
);
   import ihtd_pkg::*;

   logic [MASK_BITS-1:0]   mask_ff    [SLOT_COUNT];
   logic [VECTOR_BITS-1:0] handler_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mask_ff[wr.idx]    <= wr.mask;
         handler_ff[wr.idx] <= wr.handler;
      end
   end

   // empty slots read as zero
   always_comb begin
      rd_mask    = valid_ff[rd_idx] ? mask_ff[rd_idx]    : '0;
      rd_handler = valid_ff[rd_idx] ? handler_ff[rd_idx] : '0;
   end

endmodule

@@ rtl/ihtd_match_unit.sv @@
// ----------------------------------------------------------------------------
// ihtd_match_unit
// Shared compare unit, checks one slot against the search key per cycle.
// ----------------------------------------------------------------------------
module ihtd_match_unit (
   input  logic                             dispatch,
   input  logic                             last,
   input  logic [ihtd_pkg::MASK_BITS-1:0]   key,
   input  logic [ihtd_pkg::MASK_BITS-1:0]   entry_mask,
   input  logic [ihtd_pkg::VECTOR_BITS-1:0] entry_handler,
   output ihtd_pkg::match_result_type       result
);
   import ihtd_pkg::*;

   logic empty;
   logic equal;
   logic overlap;

   always_comb begin
      empty   = (entry_mask == '0);
      equal   = (entry_mask == key);
      overlap = ((entry_mask & key) != '0) && (entry_handler != '0);
      if (dispatch) begin
         result.found = overlap;
         result.done  = empty || overlap || last;
      end else begin
         result.found = empty || equal;
         result.done  = empty || equal || last;
      end
   end

endmodule

@@ rtl/irq_handler_table_dispatch.sv @@
// ----------------------------------------------------------------------------
// irq_handler_table_dispatch
// Vectored interrupt handler table with register, query and dispatch.
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one command per transfer: register a handler, query
//   a handler, or dispatch pending flags. rsp channel returns one result per
//   command. csr channel writes the fifo flag mask and is always ready; write
//   it only while no command is in flight.
// timing:
//   after a transfer the table is walked one slot per cycle through a single
//   compare unit, stopping at the chosen slot, the first empty slot or the
//   last slot; a zero mask on register or query skips the walk. req_tready
//   is high only while idle.
// reset:
//   all slots read as empty, the fifo flag mask returns to 0x00040000 and
//   no result is pending.
// stall:
//   a finished result waits in the block until the rsp register is free;
//   req stays not ready during that time.
// ----------------------------------------------------------------------------
module irq_handler_table_dispatch (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // irq_mask [31:0], handler_id [39:32], irq_flags [71:40]
   input  logic [ihtd_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // cmd [1:0]
   input  logic [ihtd_pkg::CMD_BITS-1:0]         req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // old_handler [7:0], fifo_service [8], dispatch_handler [16:9],
   // dispatch_slot [20:17], zero [23:21]
   output logic [ihtd_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // status [1:0]
   output logic [ihtd_pkg::STATUS_BITS-1:0]      rsp_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ihtd_pkg::MASK_BITS-1:0]        csr_data
);
   import ihtd_pkg::*;

   state_type              state_ff, state_in;
   logic [SLOT_BITS-1:0]   idx_ff, idx_in;
   logic [CMD_BITS-1:0]    cmd_ff, cmd_in;
   logic [MASK_BITS-1:0]   key_ff, key_in;
   logic [ID_BITS-1:0]     hid_ff, hid_in;
   logic [MASK_BITS-1:0]   fifo_mask_ff;

   status_type             res_status_ff, res_status_in;
   logic [ID_BITS-1:0]     res_old_ff, res_old_in;
   logic                   res_fifo_ff, res_fifo_in;
   logic [ID_BITS-1:0]     res_dh_ff, res_dh_in;
   logic [DSLOT_BITS-1:0]  res_ds_ff, res_ds_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_BITS-1:0]   rsp_user_ff, rsp_user_in;

   logic [MASK_BITS-1:0]   req_mask;
   logic [ID_BITS-1:0]     req_hid;
   logic [MASK_BITS-1:0]   req_flags;
   logic                   req_xfer;
   logic                   req_zero;
   logic                   rsp_free;
   logic                   load_rsp;

   logic [MASK_BITS-1:0]   entry_mask;
   logic [VECTOR_BITS-1:0] entry_handler;
   logic                   last;
   match_result_type       match;
   table_write_type        tbl_wr;

   assign req_mask  = req_tdata[31:0];
   assign req_hid   = req_tdata[39:32];
   assign req_flags = req_tdata[71:40];
   assign req_xfer  = req_tvalid && req_tready;
   assign req_zero  = !req_tuser[1] && (req_mask == '0);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign last      = (idx_ff == SLOT_BITS'(SLOT_COUNT - 1));
   assign csr_ready = 1'b1;

   ihtd_table u_table (
      .clock      (clock),
      .reset      (reset),
      .wr         (tbl_wr),
      .rd_idx     (idx_ff),
      .rd_mask    (entry_mask),
      .rd_handler (entry_handler)
   );

   ihtd_match_unit u_match (
      .dispatch      (cmd_ff[1]),
      .last          (last),
      .key           (key_ff),
      .entry_mask    (entry_mask),
      .entry_handler (entry_handler),
      .result        (match)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = req_zero ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_tready    = 1'b0;
      load_rsp      = 1'b0;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      hid_in        = hid_ff;
      res_status_in = res_status_ff;
      res_old_in    = res_old_ff;
      res_fifo_in   = res_fifo_ff;
      res_dh_in     = res_dh_ff;
      res_ds_in     = res_ds_ff;
      tbl_wr.en      = 1'b0;
      tbl_wr.idx     = idx_ff;
      tbl_wr.mask    = key_ff;
      tbl_wr.handler = VECTOR_BITS'(hid_ff);
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               idx_in        = '0;
               cmd_in        = req_tuser;
               hid_in        = req_hid;
               res_old_in    = '0;
               res_dh_in     = '0;
               res_ds_in     = '0;
               res_fifo_in   = req_tuser[1] && ((req_flags & fifo_mask_ff) != '0);
               key_in        = req_tuser[1] ? (req_flags & ~fifo_mask_ff) : req_mask;
               res_status_in = req_zero ? STATUS_ZERO_MASK : STATUS_OK;
            end
         end
         ST_SCAN: begin
            if (match.done) begin
               if (match.found) begin
                  res_status_in = STATUS_OK;
                  if (cmd_ff[1]) begin
                     res_dh_in = ID_BITS'(entry_handler);
                     res_ds_in = DSLOT_BITS'(idx_ff);
                  end else begin
                     res_old_in = ID_BITS'(entry_handler);
                     tbl_wr.en  = (cmd_ff == CMD_REGISTER);
                  end
               end else begin
                  res_status_in = cmd_ff[1] ? STATUS_NO_MATCH : STATUS_FULL;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            load_rsp = rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, res_ds_ff, res_dh_ff, res_fifo_ff, res_old_ff};
         rsp_user_in  = res_status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fifo_mask_ff <= FIFO_MASK_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            fifo_mask_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      hid_ff        <= hid_in;
      res_status_ff <= res_status_in;
      res_old_ff    <= res_old_in;
      res_fifo_ff   <= res_fifo_in;
      res_dh_ff     <= res_dh_in;
      res_ds_ff     <= res_ds_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_write_only_on_register: assert property (@(posedge clock) disable iff (reset)
      tbl_wr.en |-> (state_ff == ST_SCAN) && (cmd_ff == CMD_REGISTER) && match.found)
      else $error("table written outside a register command");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_DONE)
      else $error("result raised without a finished command");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != ST_IDLE)
      else $error("accepted command did not start");

endmodule

@@ test/tb_irq_handler_table_dispatch.sv @@
// ----------------------------------------------------------------------------
// tb_irq_handler_table_dispatch
// Self-checking bench for the interrupt handler table and dispatcher. A short
// table of directed commands covers zero masks, vector-zero slots, the fifo
// bit, the empty-slot scan stop, command three and a full table. Randomised
// commands then run under several fifo flag masks. Every result transfer is
// compared field by field with a typed row's own result, else with a bench
// model of the slot table, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_irq_handler_table_dispatch;
   timeunit 1ns;
   timeprecision 1ps;
   import ihtd_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_DISPATCH_ALT = 2'd3;
   localparam int ITEMS_PER_PHASE = 120;
   localparam int PHASES          = 5;
   localparam int SQUEEZE_CYCLES  = 400;
   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = SLOT_COUNT + 4;

   typedef struct packed {
      logic [CMD_BITS-1:0]    cmd;
      logic [MASK_BITS-1:0]   mask;
      logic [ID_BITS-1:0]     vec;
      logic [MASK_BITS-1:0]   flags;
   } irq_cmd_type;

   typedef struct packed {
      status_type             status;
      logic [ID_BITS-1:0]     old_vec;
      logic                   fifo;
      logic [ID_BITS-1:0]     disp_vec;
      logic [DSLOT_BITS-1:0]  disp_slot;
   } irq_result_type;

   typedef struct packed {
      irq_cmd_type    item;
      logic           typed;
      irq_result_type want;
   } dir_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   logic [CMD_BITS-1:0]       req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic [STATUS_BITS-1:0]    rsp_tuser;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [MASK_BITS-1:0]      csr_data;

   logic [MASK_BITS-1:0]      slot_mask_tbl [SLOT_COUNT];
   logic [VECTOR_BITS-1:0]    slot_vec_tbl  [SLOT_COUNT];
   logic [MASK_BITS-1:0]      fifo_bits;

   irq_result_type            result_queue [$];
   dir_row_type               dir_rows [$];

   int errors = 0;
   int n_results = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   bit offering = 0;
   bit squeeze_req = 0;
   int n_settings = 1;
   int n_register = 0, n_query = 0, n_dispatch = 0;
   int n_full = 0, n_zero = 0, n_hit = 0, n_nomatch = 0, n_fifo = 0;

   irq_handler_table_dispatch uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // slot table model: returns the result and updates the table
   function automatic irq_result_type table_apply(input irq_cmd_type c);
      irq_result_type r;
      int pick;
      int i;
      bit stop;
      logic [MASK_BITS-1:0] live;
      r = '0;
      r.status = STATUS_OK;
      pick = -1;
      stop = 0;
      if (!c.cmd[1]) begin
         if (c.mask == '0) begin
            r.status = STATUS_ZERO_MASK;
         end else begin
            for (i = 0; i < SLOT_COUNT; i++) begin
               if (pick < 0 && (slot_mask_tbl[i] == '0 || slot_mask_tbl[i] == c.mask))
                  pick = i;
            end
            if (pick < 0) begin
               r.status = STATUS_FULL;
            end else begin
               r.old_vec = ID_BITS'(slot_vec_tbl[pick]);
               if (c.cmd == CMD_REGISTER) begin
                  slot_vec_tbl[pick]  = c.vec[VECTOR_BITS-1:0];
                  slot_mask_tbl[pick] = c.mask;
               end
            end
         end
      end else begin
         live = c.flags;
         if ((live & fifo_bits) != '0) begin
            r.fifo = 1'b1;
            live = live & ~fifo_bits;
         end
         r.status = STATUS_NO_MATCH;
         for (i = 0; i < SLOT_COUNT; i++) begin
            if (!stop) begin
               if (slot_mask_tbl[i] == '0) begin
                  stop = 1;
               end else if ((slot_mask_tbl[i] & live) != '0 && slot_vec_tbl[i] != '0) begin
                  r.status    = STATUS_OK;
                  r.disp_vec  = ID_BITS'(slot_vec_tbl[i]);
                  r.disp_slot = DSLOT_BITS'(i);
                  stop = 1;
               end
            end
         end
      end
      return r;
   endfunction

   function automatic irq_cmd_type pick_command();
      irq_cmd_type c;
      int r;
      c.mask  = $urandom;
      c.vec   = ID_BITS'($urandom);
      c.flags = $urandom;
      r = $urandom_range(0, 99);
      c.cmd = (r < 30) ? CMD_REGISTER : (r < 50) ? CMD_QUERY :
              (r < 92) ? CMD_DISPATCH : CMD_DISPATCH_ALT;
      r = $urandom_range(0, 99);
      if (r < 70)
         c.mask = slot_mask_tbl[$urandom_range(0, SLOT_COUNT-1)];
      else if (r < 80)
         c.mask = '0;
      else if (r < 90)
         c.mask = 32'h1 << $urandom_range(0, 31);
      if ($urandom_range(0, 3) == 0)
         c.vec = '0;
      r = $urandom_range(0, 99);
      if (r < 35)
         c.flags = 32'h1 << $urandom_range(0, 31);
      else if (r < 60)
         c.flags = slot_mask_tbl[$urandom_range(0, SLOT_COUNT-1)] & $urandom;
      else if (r < 70)
         c.flags = '0;
      else if (r < 85)
         c.flags = fifo_bits | (32'h1 << $urandom_range(0, 31));
      return c;
   endfunction

   function automatic void add_row(input logic [CMD_BITS-1:0] cmd,
                                   input logic [MASK_BITS-1:0] mask,
                                   input logic [ID_BITS-1:0] vec,
                                   input logic [MASK_BITS-1:0] flags,
                                   input int typed, input status_type st,
                                   input logic [ID_BITS-1:0] old_vec, input int fifo);
      dir_row_type row;
      row = '0;
      row.item.cmd   = cmd;
      row.item.mask  = mask;
      row.item.vec   = vec;
      row.item.flags = flags;
      row.typed        = (typed != 0);
      row.want.status  = st;
      row.want.old_vec = old_vec;
      row.want.fifo    = (fifo != 0);
      dir_rows.push_back(row);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      if (errors <= 40)
         $display("ERROR %0t result %0d %s: got 0x%0h want 0x%0h",
                  $time, n_results, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   task automatic send_item(input irq_cmd_type c, input logic typed,
                            input irq_result_type want);
      irq_result_type model;
      req_tvalid <= 1'b1;
      req_tdata  <= {c.flags, c.vec, c.mask};
      req_tuser  <= c.cmd;
      offering = 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model = table_apply(c);
      result_queue.push_back(typed ? want : model);
      if (c.cmd == CMD_REGISTER) n_register++;
      else if (c.cmd == CMD_QUERY) n_query++;
      else n_dispatch++;
      case (model.status)
         STATUS_FULL:      n_full++;
         STATUS_ZERO_MASK: n_zero++;
         STATUS_NO_MATCH:  n_nomatch++;
         default:          if (c.cmd[1]) n_hit++;
      endcase
      if (model.fifo) n_fifo++;
      @(negedge clock);
   endtask

   task automatic sender_pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         offering = 0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic wait_idle();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 0;
      end
      while (result_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_fifo_mask(input logic [MASK_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      fifo_bits = value;
      n_settings++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result side: stall pattern plus one long hold-off
   initial begin
      int hold;
      int mode;
      int mode_left;
      bit squeeze_done;
      hold = 0;
      mode = 0;
      mode_left = 0;
      squeeze_done = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (squeeze_req && !squeeze_done) begin
            hold = SQUEEZE_CYCLES;
            squeeze_done = 1;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      irq_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (result_queue.size() == 0) begin
            report_mismatch("unexpected transfer", 32'(rsp_tdata), '0);
         end else begin
            want = result_queue.pop_front();
            check_field("status", 32'(rsp_tuser), 32'(want.status));
            check_field("old_handler", 32'(rsp_tdata[7:0]), 32'(want.old_vec));
            check_field("fifo_service", 32'(rsp_tdata[8]), 32'(want.fifo));
            check_field("dispatch_handler", 32'(rsp_tdata[16:9]), 32'(want.disp_vec));
            check_field("dispatch_slot", 32'(rsp_tdata[20:17]), 32'(want.disp_slot));
            check_field("padding", 32'(rsp_tdata[23:21]), '0);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("irq_handler_table_dispatch: mismatch");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      fifo_bits  = FIFO_MASK_RESET;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_mask_tbl[i] = '0;
         slot_vec_tbl[i]  = '0;
      end

      add_row(CMD_QUERY,    '0,           8'h00, 32'hFFFF_FFFF, 1, STATUS_ZERO_MASK, 8'h00, 0);
      add_row(CMD_REGISTER, '0,           8'hFF, '0,            1, STATUS_ZERO_MASK, 8'h00, 0);
      add_row(CMD_DISPATCH, '0,           8'h00, 32'hFFFF_FFFF, 1, STATUS_NO_MATCH,  8'h00, 1);
      add_row(CMD_REGISTER, 32'h1,        8'hFF, '0,            1, STATUS_OK,        8'h00, 0);
      add_row(CMD_REGISTER, 32'h2,        8'h00, '0,            0, STATUS_OK,        8'h00, 0);
      add_row(CMD_REGISTER, 32'h6,        8'h11, '0,            0, STATUS_OK,        8'h00, 0);
      // vector-zero slot skipped, fifo bit removed
      add_row(CMD_DISPATCH, '0,           8'h00, 32'h0004_0002, 0, STATUS_OK,        8'h00, 0);
      add_row(CMD_REGISTER, 32'h1,        8'h5A, '0,            1, STATUS_OK,        8'hFF, 0);
      add_row(CMD_QUERY,    32'h1,        8'h00, '0,            0, STATUS_OK,        8'h00, 0);
      add_row(CMD_DISPATCH_ALT, '0,       8'h00, 32'h1,         0, STATUS_OK,        8'h00, 0);
      // scan stops at the first empty slot
      add_row(CMD_DISPATCH, '0,           8'h00, 32'h100,       0, STATUS_OK,        8'h00, 0);
      add_row(CMD_REGISTER, 32'hFFFF_FFFF, 8'h80, '0,           0, STATUS_OK,        8'h00, 0);
      for (int k = 0; k < SLOT_COUNT - 4; k++)
         add_row(CMD_REGISTER, 32'h100 << k, 8'(k + 1), '0,     0, STATUS_OK,        8'h00, 0);
      add_row(CMD_REGISTER, 32'h3,        8'h33, '0,            1, STATUS_FULL,      8'h00, 0);
      add_row(CMD_QUERY,    32'h3,        8'h00, '0,            1, STATUS_FULL,      8'h00, 0);
      add_row(CMD_DISPATCH, '0,           8'h00, 32'h8000_0000, 0, STATUS_OK,        8'h00, 0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
         sender_pace();
      end

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_idle();
            case (p)
               1:       write_fifo_mask('0);
               2:       write_fifo_mask(32'hFFFF_FFFF);
               3:       write_fifo_mask($urandom | (32'h1 << $urandom_range(0, 31)));
               default: write_fifo_mask((32'h1 << $urandom_range(0, 31)) |
                                        (32'h1 << $urandom_range(0, 31)));
            endcase
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 0 && n == 20)
               squeeze_req = 1;
            send_item(pick_command(), 1'b0, '0);
            sender_pace();
         end
      end
      wait_idle();

      $display("summary: %0d transfers (%0d register, %0d query, %0d dispatch), %0d fifo masks",
               n_register + n_query + n_dispatch, n_register, n_query, n_dispatch, n_settings);
      $display("summary: %0d full, %0d zero mask, %0d hits, %0d no match, %0d fifo service",
               n_full, n_zero, n_hit, n_nomatch, n_fifo);
      if (errors == 0)
         $display("irq_handler_table_dispatch: match");
      else
         $display("irq_handler_table_dispatch: mismatch");
      $finish;
   end

endmodule
